// ----- design/ekd_pkg.sv -----
`default_nettype none

package ekd_pkg;

  // key codes carried through the queue and on the result channel
  localparam int KEY_W = 9;
  typedef logic [KEY_W-1:0] key_t;

  localparam key_t K_ESC   = 9'd27;
  localparam key_t K_QUIT  = 9'd17;
  localparam key_t K_UP    = 9'd256;
  localparam key_t K_DOWN  = 9'd257;
  localparam key_t K_LEFT  = 9'd258;
  localparam key_t K_RIGHT = 9'd259;
  localparam key_t K_PGUP  = 9'd260;
  localparam key_t K_PGDN  = 9'd261;
  localparam key_t K_HOME  = 9'd262;
  localparam key_t K_END   = 9'd263;

  // screen size registers
  localparam int DIM_W = 9;
  localparam logic [DIM_W-1:0] MAX_DIM       = 9'd256;
  localparam logic [DIM_W-1:0] COLS_RESET    = 9'd80;
  localparam logic [DIM_W-1:0] ROWS_RESET    = 9'd24;
  localparam logic             REG_COLS      = 1'b0;
  localparam logic             REG_ROWS      = 1'b1;

  // key queue between parser and cursor unit (power of two depth)
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // parser phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_PREFIX,
    PH_DIGIT
  } phase_t;

  // decoded key handed from the parser to the queue
  typedef struct packed {
    logic valid;
    key_t key;
  } key_push_t;

endpackage

`default_nettype wire

// ----- design/ekd_parse.sv -----
`default_nettype none

module ekd_parse
  import ekd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // in_byte
  input  wire logic [0:0] s_tuser,   // is_timeout
  input  wire logic       q_full,
  output key_push_t       push
);

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_BRACK = 8'h5b;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_F     = 8'h46;

  phase_t     phase, phase_next;
  logic [7:0] prefix, prefix_next;
  logic [7:0] digit, digit_next;
  logic       acc;
  logic       tmo;
  logic [7:0] b;

  // letter after the CSI or SS3 prefix
  function automatic key_t decode_letter(input logic [7:0] c);
    key_t k;
    unique case (c)
      8'h41:   k = K_UP;
      8'h42:   k = K_DOWN;
      8'h43:   k = K_RIGHT;
      8'h44:   k = K_LEFT;
      8'h48:   k = K_HOME;
      8'h46:   k = K_END;
      default: k = K_ESC;
    endcase
    return k;
  endfunction

  // digit of a tilde sequence
  function automatic key_t decode_tilde(input logic [7:0] d);
    key_t k;
    unique case (d)
      8'h31, 8'h37: k = K_HOME;
      8'h34, 8'h38: k = K_END;
      8'h35:        k = K_PGUP;
      8'h36:        k = K_PGDN;
      default:      k = K_ESC;
    endcase
    return k;
  endfunction

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;
  assign tmo      = s_tuser[0];
  assign b        = s_tdata;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      prefix <= '0;
      digit  <= '0;
    end else begin
      phase  <= phase_next;
      prefix <= prefix_next;
      digit  <= digit_next;
    end
  end

  // next phase and decoded key
  always_comb begin
    phase_next  = phase;
    prefix_next = prefix;
    digit_next  = digit;
    push.valid  = 1'b0;
    push.key    = K_ESC;
    if (acc) begin
      unique case (phase)
        PH_IDLE: begin
          if (!tmo) begin
            if (b == CH_ESC) begin
              phase_next = PH_ESC;
            end else begin
              push.valid = 1'b1;
              push.key   = {1'b0, b};
            end
          end
        end
        PH_ESC: begin
          if (tmo) begin
            push.valid = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            prefix_next = b;
            phase_next  = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          if (tmo) begin
            push.valid = 1'b1;
            phase_next = PH_IDLE;
          end else if (prefix == CH_BRACK && b >= CH_ZERO && b <= CH_NINE) begin
            digit_next = b;
            phase_next = PH_DIGIT;
          end else begin
            if (prefix == CH_BRACK) begin
              push.key = decode_letter(b);
            end else if (prefix == CH_O && (b == CH_H || b == CH_F)) begin
              push.key = decode_letter(b);
            end
            push.valid = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_DIGIT: begin
          if (!tmo && b == CH_TILDE) begin
            push.key = decode_tilde(digit);
          end
          push.valid = 1'b1;
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // a timeout inside a sequence always ends it with a key
  a_tmo_emits: assert property (@(posedge clk) disable iff (rst)
    (acc && tmo && phase != PH_IDLE) |-> (push.valid && push.key == K_ESC))
    else $error("timeout inside a sequence gave no escape key");

  // a tilde sequence never outlasts its fourth byte
  a_digit_ends: assert property (@(posedge clk) disable iff (rst)
    (acc && phase == PH_DIGIT) |=> (phase == PH_IDLE))
    else $error("parser stuck after digit");

endmodule

`default_nettype wire

// ----- design/ekd_queue.sv -----
`default_nettype none

module ekd_queue
  import ekd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire key_push_t push,
  output logic           full,
  output logic           q_valid,
  output key_t           q_key,
  input  wire logic      pop
);

  key_t            entry [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [Q_CW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == Q_CW'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_key   = entry[rptr];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && q_valid;

  // storage, pointers wrap naturally since the depth is a power of two
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no key may be dropped at a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("key pushed into full queue");

endmodule

`default_nettype wire

// ----- design/ekd_cursor.sv -----
`default_nettype none

module ekd_cursor
  import ekd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [DIM_W-1:0] screen_cols,
  input  wire logic [DIM_W-1:0] screen_rows,
  input  wire logic             q_valid,
  input  wire key_t             q_key,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [31:0]           m_tdata,   // key_code, cursor_col, cursor_row, zero fill
  output logic [0:0]            m_tuser    // quit_request
);

  logic [7:0]       col, col_next;
  logic [7:0]       row, row_next;
  logic [DIM_W-1:0] eff_cols;
  logic [DIM_W-1:0] eff_rows;
  logic [7:0]       last_col;
  logic [7:0]       last_row;
  key_t             out_key;
  logic [7:0]       out_col;
  logic [7:0]       out_row;
  logic             out_quit;

  // screen size clamped to one through the maximum
  always_comb begin
    eff_cols = screen_cols;
    eff_rows = screen_rows;
    if (screen_cols == '0) eff_cols = DIM_W'(1);
    if (screen_cols > MAX_DIM) eff_cols = MAX_DIM;
    if (screen_rows == '0) eff_rows = DIM_W'(1);
    if (screen_rows > MAX_DIM) eff_rows = MAX_DIM;
  end

  assign last_col = 8'(eff_cols - DIM_W'(1));
  assign last_row = 8'(eff_rows - DIM_W'(1));

  // output register takes a new key whenever it is empty or drained
  assign pop = q_valid && (!m_tvalid || m_tready);

  // cursor move for the key at the queue head
  always_comb begin
    col_next = col;
    row_next = row;
    unique case (q_key)
      K_UP:    if (row != '0) row_next = row - 8'd1;
      K_DOWN:  if (row < last_row) row_next = row + 8'd1;
      K_LEFT:  if (col != '0) col_next = col - 8'd1;
      K_RIGHT: if (col < last_col) col_next = col + 8'd1;
      K_PGUP:  row_next = ({1'b0, row} > eff_rows) ? 8'(row - eff_rows[7:0]) : 8'd0;
      K_PGDN:  if (row < last_row) row_next = last_row;
      K_HOME:  col_next = 8'd0;
      K_END:   col_next = last_col;
      default: ;
    endcase
  end

  // cursor and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        col      <= col_next;
        row      <= row_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_key  <= q_key;
      out_col  <= col_next;
      out_row  <= row_next;
      out_quit <= (q_key == K_QUIT);
    end
  end

  assign m_tdata = {7'd0, out_row, out_col, out_key};
  assign m_tuser = out_quit;

  // ctrl-q leaves the cursor where it was
  a_quit_holds: assert property (@(posedge clk) disable iff (rst)
    (pop && q_key == K_QUIT) |=> (col == $past(col) && row == $past(row)))
    else $error("quit key moved the cursor");

  // a result shows the cursor as it now stands
  a_result_cursor: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_col == col && out_row == row))
    else $error("result cursor differs from cursor state");

endmodule

`default_nettype wire

// ----- design/escape_key_decoder_cursor.sv -----
// channel  | dir | signals                      | payload
// ---------+-----+------------------------------+------------------------------------------
// s_axis   | in  | s_tvalid s_tready s_tdata/user| tdata: in_byte; tuser: is_timeout
// m_axis   | out | m_tvalid m_tready m_tdata/user| tdata: key_code, cursor_col, cursor_row
//          |     |                              | tuser: quit_request
// cfg      | in  | cfg_we cfg_index cfg_wdata   | 0 screen_cols, 1 screen_rows
//
// one input transfer per cycle while the key queue has room; a decoded key passes from the
// parser into the key queue and then from the cursor unit into the output register
// rst is synchronous: parser idle, cursor at 0,0, screen 80 by 24, queue empty
// s_tready drops only when the two-entry key queue is full; m_tready low stalls the
// cursor unit while the parser keeps taking bytes until the queue fills
`default_nettype none

module escape_key_decoder_cursor
  import ekd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // in_byte
  input  wire logic [0:0]       s_tuser,   // is_timeout
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [31:0]           m_tdata,   // key_code, cursor_col, cursor_row, zero fill
  output logic [0:0]            m_tuser,   // quit_request
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [DIM_W-1:0] cfg_wdata
);

  logic [DIM_W-1:0] screen_cols;
  logic [DIM_W-1:0] screen_rows;
  key_push_t        push;
  logic             q_full;
  logic             q_valid;
  key_t             q_key;
  logic             pop;

  // screen size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_cols <= COLS_RESET;
      screen_rows <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS: screen_cols <= cfg_wdata;
        REG_ROWS: screen_rows <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  ekd_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push)
  );

  ekd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (q_full),
    .q_valid (q_valid),
    .q_key   (q_key),
    .pop     (pop)
  );

  ekd_cursor u_cursor (
    .clk         (clk),
    .rst         (rst),
    .screen_cols (screen_cols),
    .screen_rows (screen_rows),
    .q_valid     (q_valid),
    .q_key       (q_key),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
module testbench;
  import ekd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int RANDOM_BLOCKS = 8;
  localparam int BLOCK_ITEMS   = 75;

  localparam logic [7:0] CH_CSI   = 8'h5b;  // '['
  localparam logic [7:0] CH_SS3   = 8'h4f;  // 'O'
  localparam logic [7:0] CH_TILDE = 8'h7e;  // '~'

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  // one decoded key with the cursor after it
  typedef struct packed {
    key_t       key;
    logic [7:0] col;
    logic [7:0] row;
    logic       quit;
  } key_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;   // in_byte
  logic [0:0]       s_tuser = 1'b0;    // is_timeout
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;           // key_code, cursor_col, cursor_row, zero fill
  logic [0:0]       m_tuser;           // quit_request
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [DIM_W-1:0] cfg_wdata = '0;

  // decoder and cursor state mirrored by the testbench
  phase_t      parse_state;
  logic [7:0]  esc_prefix;
  logic [7:0]  esc_digit;
  logic [7:0]  cur_col;
  logic [7:0]  cur_row;
  logic [8:0]  screen_cols;
  logic [8:0]  screen_rows;

  key_result_t expected_keys[$];
  int          mismatch_count = 0;
  int          useful_items = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;

  escape_key_decoder_cursor u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [8:0] eff_dim(logic [8:0] v);
    if (v == 9'd0) return 9'd1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [7:0] last_idx(logic [8:0] v);
    logic [8:0] d;
    d = eff_dim(v) - 9'd1;
    return d[7:0];
  endfunction

  function automatic key_t csi_letter_key(logic [7:0] b);
    case (b)
      "A": return K_UP;
      "B": return K_DOWN;
      "C": return K_RIGHT;
      "D": return K_LEFT;
      "H": return K_HOME;
      "F": return K_END;
      default: return K_ESC;
    endcase
  endfunction

  function automatic key_t tilde_key(logic [7:0] d);
    case (d)
      "1", "7": return K_HOME;
      "4", "8": return K_END;
      "5": return K_PGUP;
      "6": return K_PGDN;
      default: return K_ESC;
    endcase
  endfunction

  // cursor movement, held inside the screen for down, right, page down, end
  function automatic void move_cursor(key_t key);
    logic [7:0] lc;
    logic [7:0] lr;
    logic [8:0] nr;
    lc = last_idx(screen_cols);
    lr = last_idx(screen_rows);
    nr = eff_dim(screen_rows);
    case (key)
      K_UP:    if (cur_row != 8'd0) cur_row = cur_row - 8'd1;
      K_DOWN:  if (cur_row < lr) cur_row = cur_row + 8'd1;
      K_LEFT:  if (cur_col != 8'd0) cur_col = cur_col - 8'd1;
      K_RIGHT: if (cur_col < lc) cur_col = cur_col + 8'd1;
      K_PGUP:  cur_row = ({1'b0, cur_row} > nr) ? cur_row - nr[7:0] : 8'd0;
      K_PGDN:  if (cur_row < lr) cur_row = lr;
      K_HOME:  cur_col = 8'd0;
      K_END:   cur_col = lc;
      default: ;
    endcase
  endfunction

  // parser step for one accepted transfer, queues the key it yields
  function automatic void predict_transfer(logic tmo, logic [7:0] b);
    logic        have;
    key_t        key;
    key_result_t res;
    have = 1'b0;
    key = K_ESC;
    if (!(tmo && parse_state == PH_IDLE)) useful_items++;
    case (parse_state)
      PH_IDLE: begin
        if (!tmo) begin
          if (b == K_ESC[7:0]) begin
            parse_state = PH_ESC;
          end else begin
            key = {1'b0, b};
            have = 1'b1;
          end
        end
      end
      PH_ESC: begin
        if (tmo) begin
          have = 1'b1;
          parse_state = PH_IDLE;
        end else begin
          esc_prefix = b;
          parse_state = PH_PREFIX;
        end
      end
      PH_PREFIX: begin
        if (tmo) begin
          have = 1'b1;
          parse_state = PH_IDLE;
        end else if (esc_prefix == CH_CSI && b >= "0" && b <= "9") begin
          esc_digit = b;
          parse_state = PH_DIGIT;
        end else begin
          if (esc_prefix == CH_CSI)
            key = csi_letter_key(b);
          else if (esc_prefix == CH_SS3 && (b == "H" || b == "F"))
            key = csi_letter_key(b);
          have = 1'b1;
          parse_state = PH_IDLE;
        end
      end
      default: begin
        if (!tmo && b == CH_TILDE) key = tilde_key(esc_digit);
        have = 1'b1;
        parse_state = PH_IDLE;
      end
    endcase
    if (have) begin
      move_cursor(key);
      res.key = key;
      res.col = cur_col;
      res.row = cur_row;
      res.quit = (key == K_QUIT);
      expected_keys.push_back(res);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.key = m_tdata[8:0];
      got.col = m_tdata[16:9];
      got.row = m_tdata[24:17];
      got.quit = m_tuser[0];
      if (expected_keys.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: key %0d col %0d row %0d quit %0d",
                   got.key, got.col, got.row, got.quit);
      end else begin
        want = expected_keys.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected key %0d col %0d row %0d quit %0d,",
                     want.key, want.col, want.row, want.quit,
                     " got key %0d col %0d row %0d quit %0d",
                     got.key, got.col, got.row, got.quit);
        end
      end
    end
  end

  // one input transfer, called and returning at a falling edge
  task automatic send_item(input logic tmo, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= tmo;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_transfer(tmo, b);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b);
  endtask

  task automatic send_timeout();
    send_item(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic send_esc_pair(input logic [7:0] prefix, input logic [7:0] last_b);
    send_byte(K_ESC[7:0]);
    send_byte(prefix);
    send_byte(last_b);
  endtask

  task automatic send_esc_digit(input logic [7:0] d, input logic [7:0] last_b);
    send_byte(K_ESC[7:0]);
    send_byte(CH_CSI);
    send_byte(d);
    send_byte(last_b);
  endtask

  // stop offering, wait for every pending key, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_keys.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_screen(input logic idx, input logic [8:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COLS) screen_cols = value;
    else screen_rows = value;
  endtask

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 71; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default:       begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
  endtask

  // one random event: half well-formed sequences, the rest noise, broken ones and timeouts
  task automatic send_random_event();
    int pick;
    int sel;
    pick = $urandom_range(99);
    if (pick < 50) begin
      sel = $urandom_range(9);
      case (sel)
        0, 1, 2, 3, 4, 5: begin
          case (sel)
            0: send_esc_pair(CH_CSI, "A");
            1: send_esc_pair(CH_CSI, "B");
            2: send_esc_pair(CH_CSI, "C");
            3: send_esc_pair(CH_CSI, "D");
            4: send_esc_pair(CH_CSI, "H");
            default: send_esc_pair(CH_CSI, "F");
          endcase
        end
        6, 7: begin
          case ($urandom_range(5))
            0: send_esc_digit("1", CH_TILDE);
            1: send_esc_digit("4", CH_TILDE);
            2: send_esc_digit("5", CH_TILDE);
            3: send_esc_digit("6", CH_TILDE);
            4: send_esc_digit("7", CH_TILDE);
            default: send_esc_digit("8", CH_TILDE);
          endcase
        end
        default: send_esc_pair(CH_SS3, ($urandom_range(1) != 0) ? "H" : "F");
      endcase
    end else if (pick < 65) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 72) begin
      send_byte(K_QUIT[7:0]);
    end else if (pick < 88) begin
      case ($urandom_range(4))
        0: begin
          send_byte(K_ESC[7:0]);
          send_timeout();
        end
        1: begin
          send_byte(K_ESC[7:0]);
          send_byte(CH_CSI);
          send_timeout();
        end
        2: begin
          send_byte(K_ESC[7:0]);
          send_byte(CH_CSI);
          send_byte(8'($urandom_range(8'h39, 8'h30)));
          if ($urandom_range(1) != 0) send_timeout();
          else send_byte(8'($urandom_range(255)));
        end
        3: send_esc_pair(8'($urandom_range(255)), 8'($urandom_range(255)));
        default: send_esc_pair(CH_SS3, 8'($urandom_range(255)));
      endcase
    end else begin
      send_timeout();
    end
  endtask

  // plain bytes at the field extremes, ctrl-q, and an ignored timeout
  task automatic test_plain_keys();
    set_idling(IDLE_NONE);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_timeout();
    send_byte(K_QUIT[7:0]);
  endtask

  task automatic test_escape_sequences();
    set_idling(IDLE_NONE);
    send_esc_pair(CH_CSI, "C");
    send_esc_digit("6", CH_TILDE);
    send_esc_pair(CH_SS3, "F");
  endtask

  // timeout inside a sequence, unknown digit, unknown ss3 letter
  task automatic test_broken_sequences();
    set_idling(IDLE_NONE);
    send_byte(K_ESC[7:0]);
    send_timeout();
    send_esc_digit("3", CH_TILDE);
    send_esc_pair(CH_SS3, "A");
  endtask

  // largest screen, then a one by one screen with the cursor left outside, then 256 by one
  task automatic test_screen_limits();
    set_idling(IDLE_NONE);
    write_screen(REG_COLS, 9'd511);
    write_screen(REG_ROWS, 9'd511);
    send_esc_pair(CH_CSI, "F");
    send_esc_digit("6", CH_TILDE);
    send_esc_pair(CH_CSI, "C");
    send_esc_pair(CH_CSI, "B");
    write_screen(REG_COLS, 9'd0);
    write_screen(REG_ROWS, 9'd0);
    send_esc_pair(CH_CSI, "B");
    send_esc_pair(CH_CSI, "C");
    send_esc_digit("6", CH_TILDE);
    send_esc_digit("5", CH_TILDE);
    send_esc_pair(CH_CSI, "D");
    send_esc_pair(CH_CSI, "F");
    write_screen(REG_COLS, 9'd256);
    write_screen(REG_ROWS, 9'd1);
    send_esc_pair(CH_CSI, "F");
    send_esc_pair(CH_CSI, "A");
  endtask

  // random traffic over several screen sizes and idling modes
  task automatic test_random_traffic();
    logic [8:0] cols_list[RANDOM_BLOCKS];
    logic [8:0] rows_list[RANDOM_BLOCKS];
    int         target;
    cols_list = '{9'd80, 9'd256, 9'd3, 9'd511, 9'd1, 9'd200, 9'd0, 9'd17};
    rows_list = '{9'd24, 9'd256, 9'd2, 9'd1, 9'd511, 9'd5, 9'd0, 9'd100};
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      write_screen(REG_COLS, cols_list[blk]);
      write_screen(REG_ROWS, rows_list[blk]);
      set_idling(idling_t'(blk % 4));
      target = useful_items + BLOCK_ITEMS;
      while (useful_items < target) send_random_event();
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    settle();
    set_idling(IDLE_NONE);
    hold_cycles = 80;
    for (int i = 0; i < 12; i++) begin
      send_byte(8'($urandom_range(255)));
      send_esc_pair(CH_CSI, "B");
    end
  endtask

  initial begin
    parse_state = PH_IDLE;
    esc_prefix  = 8'h00;
    esc_digit   = 8'h00;
    cur_col     = 8'd0;
    cur_row     = 8'd0;
    screen_cols = COLS_RESET;
    screen_rows = ROWS_RESET;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_plain_keys();
    test_escape_sequences();
    test_broken_sequences();
    test_screen_limits();
    test_random_traffic();
    test_backpressure();

    settle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_keys.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ekd_pkg.sv
design/ekd_parse.sv
design/ekd_queue.sv
design/ekd_cursor.sv
design/escape_key_decoder_cursor.sv
sim/testbench.sv
